// ===== design/slx_pkg.sv =====
// slx_pkg: shared types, character codes, token kinds and classifiers for
// the shell command lexer. No dependencies; used by every design module.
`default_nettype none

package slx_pkg;

    // Line length limit and position width (position field is 11 bits).
    localparam int POS_W   = 11;
    localparam int MAX_LEN = 1024;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

    // Results per character and bundle queue depth.
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Token kinds.
    localparam logic [2:0] K_IN   = 3'd0;
    localparam logic [2:0] K_OUT  = 3'd1;
    localparam logic [2:0] K_PIPE = 3'd2;
    localparam logic [2:0] K_STR  = 3'd3;
    localparam logic [2:0] K_VAR  = 3'd4;
    localparam logic [2:0] K_ERR  = 3'd5;
    localparam logic [2:0] K_END  = 3'd6;

    // Character codes.
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_USCORE  = 8'h5F;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       kind;
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] stop_pos;
        logic             run_last;
    } t_out_item;

    typedef struct packed {
        logic [2:0]       kind;
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] stop_pos;
    } t_result;

    // All results caused by one character, first result in res[0].
    typedef struct packed {
        logic [CNT_W-1:0]              count;
        t_result [MAX_RESULTS-1:0]     res;
    } t_bundle;

    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_USCORE || c == CH_DASH;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

`default_nettype wire

// ===== design/shell_command_lexer.sv =====
// shell_command_lexer: top level of the streaming command-line lexer.
// Instantiates slx_front, slx_queue and slx_back; depends on slx_pkg.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+------------------------------------
//   input   | in  | i_valid / o_stall  | i_data  (ch, line_end)
//   result  | out | o_valid / i_stall  | o_data  (kind, start_pos, stop_pos,
//           |     |                    |          run_last)
//
// Flow: the front lexes one character per cycle while the queue is not full
// and writes all of its results (one to three) into a four-entry bundle queue
// at its accepting edge. The back moves one result per cycle into the output
// register while i_stall does not hold it; the output port sets the sustained
// rate. The first result passes through the bundle queue and then the output
// register. A character that causes no result never enters the queue.
// Reset: synchronous, active low; clears lexer mode, positions, queue pointers
// and output valid. The first character may follow in the cycle after reset.
// Stalls: o_stall rises only while the queue is full; i_stall holds the
// output register and the back, while the front keeps filling the queue.
`default_nettype none

module shell_command_lexer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire slx_pkg::t_in_item  i_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output slx_pkg::t_out_item      o_data
);

    logic             in_accept;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_avail;
    slx_pkg::t_bundle q_in;
    slx_pkg::t_bundle q_head;

    // Accept a character whenever the queue has room for its bundle.
    assign o_stall   = q_full;
    assign in_accept = i_valid && !q_full;

    slx_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_data),
        .o_push   (q_push),
        .o_bundle (q_in)
    );

    slx_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_in),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_avail     (q_avail),
        .o_head      (q_head)
    );

    slx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_avail),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // The end marker always closes the results of its character.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == slx_pkg::K_END |-> o_data.run_last)
        else $error("end marker not flagged as last result");

    // An error covers exactly one character.
    a_err_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == slx_pkg::K_ERR |->
            o_data.stop_pos == o_data.start_pos + slx_pkg::POS_W'(1))
        else $error("error result does not span one character");

    // A token never ends before it begins.
    a_tok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind != slx_pkg::K_END |->
            o_data.stop_pos >= o_data.start_pos)
        else $error("token stop position precedes start position");

    // Nothing is written into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("bundle written into full queue");

endmodule

`default_nettype wire

// ===== design/slx_front.sv =====
// slx_front: accepts characters, runs the lexer state and packs the results
// of each character into one bundle. Depends on slx_pkg.
`default_nettype none

module slx_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire slx_pkg::t_in_item i_item,
    output logic                   o_push,
    output slx_pkg::t_bundle       o_bundle
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_WORD = 3'd1;
    localparam logic [2:0] M_VAR  = 3'd2;
    localparam logic [2:0] M_STR  = 3'd3;
    localparam logic [2:0] M_ESC  = 3'd4;
    localparam logic [2:0] M_DROP = 3'd5;

    typedef struct packed {
        logic [2:0]                mode;
        logic [slx_pkg::POS_W-1:0] tstart;
        logic                      qdbl;
        logic                      emit;
        logic [2:0]                kind;
    } t_begin;

    logic [2:0]                r_mode, n_mode;
    logic                      r_qdbl, n_qdbl;
    logic [slx_pkg::POS_W-1:0] r_tok,  n_tok;
    logic [slx_pkg::POS_W-1:0] r_pos,  n_pos;

    logic [2:0]                mode_eff;
    logic [7:0]                c;
    logic [7:0]                delim;
    logic [slx_pkg::POS_W-1:0] pos_inc;
    logic [slx_pkg::POS_W-1:0] len;
    logic [slx_pkg::CNT_W-1:0] n;
    t_begin                    bt;

    // Lex a character that arrives while no token is pending.
    function automatic t_begin f_begin(input logic [7:0] ch,
                                       input logic [slx_pkg::POS_W-1:0] p,
                                       input logic [slx_pkg::POS_W-1:0] p1,
                                       input logic q_in,
                                       input logic [slx_pkg::POS_W-1:0] ts_in);
        t_begin b;
        b.mode   = M_IDLE;
        b.tstart = ts_in;
        b.qdbl   = q_in;
        b.emit   = 1'b0;
        b.kind   = slx_pkg::K_ERR;
        priority if (ch == slx_pkg::CH_PIPE) begin
            b.emit = 1'b1;
            b.kind = slx_pkg::K_PIPE;
        end else if (ch == slx_pkg::CH_LT) begin
            b.emit = 1'b1;
            b.kind = slx_pkg::K_IN;
        end else if (ch == slx_pkg::CH_GT) begin
            b.emit = 1'b1;
            b.kind = slx_pkg::K_OUT;
        end else if (ch == slx_pkg::CH_DQUOTE || ch == slx_pkg::CH_SQUOTE) begin
            b.mode   = M_STR;
            b.qdbl   = (ch == slx_pkg::CH_DQUOTE);
            b.tstart = p1;
        end else if (ch == slx_pkg::CH_DOLLAR) begin
            b.mode   = M_VAR;
            b.tstart = p1;
        end else if (slx_pkg::is_name_char(ch)) begin
            b.mode   = M_WORD;
            b.tstart = p;
        end else if (!slx_pkg::is_blank(ch)) begin
            b.emit = 1'b1;
            b.mode = M_DROP;
        end else begin
            b.mode = M_IDLE;
        end
        return b;
    endfunction

    always_comb begin
        c        = i_item.ch;
        mode_eff = (r_mode > M_DROP) ? M_IDLE : r_mode;
        delim    = r_qdbl ? slx_pkg::CH_DQUOTE : slx_pkg::CH_SQUOTE;
        pos_inc  = r_pos + slx_pkg::POS_W'(1);
        len      = (r_pos < slx_pkg::MAX_POS) ? pos_inc : slx_pkg::MAX_POS;
        bt       = f_begin(c, r_pos, pos_inc, r_qdbl, r_tok);

        n        = '0;
        o_bundle = '0;
        n_mode   = mode_eff;
        n_tok    = r_tok;
        n_qdbl   = r_qdbl;

        if (mode_eff != M_DROP && r_pos >= slx_pkg::MAX_POS) begin
            o_bundle.res[0] = '{slx_pkg::K_ERR, r_pos, pos_inc};
            n      = slx_pkg::CNT_W'(1);
            n_mode = M_DROP;
        end else if (mode_eff == M_WORD || mode_eff == M_VAR) begin
            if (!slx_pkg::is_name_char(c)) begin
                o_bundle.res[0] = '{(mode_eff == M_WORD) ? slx_pkg::K_STR : slx_pkg::K_VAR,
                                    r_tok, r_pos};
                n      = slx_pkg::CNT_W'(1);
                n_mode = bt.mode;
                n_tok  = bt.tstart;
                n_qdbl = bt.qdbl;
                if (bt.emit) begin
                    o_bundle.res[1] = '{bt.kind, r_pos, pos_inc};
                    n = slx_pkg::CNT_W'(2);
                end
            end
        end else if (mode_eff == M_STR) begin
            if (c == delim) begin
                o_bundle.res[0] = '{slx_pkg::K_STR, r_tok, r_pos};
                n      = slx_pkg::CNT_W'(1);
                n_mode = M_IDLE;
            end else if (c == slx_pkg::CH_BSLASH) begin
                n_mode = M_ESC;
            end
        end else if (mode_eff == M_ESC) begin
            n_mode = M_STR;
        end else if (mode_eff == M_IDLE) begin
            n_mode = bt.mode;
            n_tok  = bt.tstart;
            n_qdbl = bt.qdbl;
            if (bt.emit) begin
                o_bundle.res[0] = '{bt.kind, r_pos, pos_inc};
                n = slx_pkg::CNT_W'(1);
            end
        end

        // Line end: flush the pending token, then give the end marker.
        if (i_item.line_end) begin
            if (n_mode == M_WORD || n_mode == M_STR || n_mode == M_ESC) begin
                o_bundle.res[n[slx_pkg::IDX_W-1:0]] = '{slx_pkg::K_STR, n_tok, len};
                n = n + slx_pkg::CNT_W'(1);
            end else if (n_mode == M_VAR) begin
                o_bundle.res[n[slx_pkg::IDX_W-1:0]] = '{slx_pkg::K_VAR, n_tok, len};
                n = n + slx_pkg::CNT_W'(1);
            end
            o_bundle.res[n[slx_pkg::IDX_W-1:0]] = '{slx_pkg::K_END, '0, len};
            n      = n + slx_pkg::CNT_W'(1);
            n_mode = M_IDLE;
            n_pos  = '0;
        end else begin
            n_pos = len;
        end

        o_bundle.count = n;
        o_push         = i_accept && (n != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_qdbl <= 1'b0;
            r_tok  <= '0;
            r_pos  <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_qdbl <= n_qdbl;
            r_tok  <= n_tok;
            r_pos  <= n_pos;
        end
    end

endmodule

`default_nettype wire

// ===== design/slx_queue.sv =====
// slx_queue: short flip-flop queue of result bundles between the lexer front
// and the emit back. Depends on slx_pkg.
`default_nettype none

module slx_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire slx_pkg::t_bundle i_push_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_avail,
    output slx_pkg::t_bundle      o_head
);

    slx_pkg::t_bundle           r_mem [slx_pkg::QUEUE_DEPTH];
    logic [slx_pkg::QPTR_W-1:0] r_wr, n_wr;
    logic [slx_pkg::QPTR_W-1:0] r_rd, n_rd;
    logic [slx_pkg::QCNT_W-1:0] r_cnt;

    localparam logic [slx_pkg::QPTR_W-1:0] LAST = slx_pkg::QPTR_W'(slx_pkg::QUEUE_DEPTH - 1);

    assign o_full  = (r_cnt == slx_pkg::QCNT_W'(slx_pkg::QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign n_wr    = (r_wr == LAST) ? '0 : r_wr + slx_pkg::QPTR_W'(1);
    assign n_rd    = (r_rd == LAST) ? '0 : r_rd + slx_pkg::QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + slx_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - slx_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/slx_back.sv =====
// slx_back: walks the head bundle one result per cycle into the output
// register while the output is not stalled. Depends on slx_pkg.
`default_nettype none

module slx_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_avail,
    input  wire slx_pkg::t_bundle i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output slx_pkg::t_out_item    o_data
);

    logic [slx_pkg::IDX_W-1:0] r_idx;
    logic                      r_valid;
    slx_pkg::t_out_item        r_data;
    logic                      out_free;
    logic                      take;
    logic                      is_last;
    slx_pkg::t_result          sel;

    assign out_free = !r_valid || !i_stall;
    assign take     = out_free && i_avail;
    assign sel      = i_head.res[r_idx];
    assign is_last  = (slx_pkg::CNT_W'(r_idx) == i_head.count - slx_pkg::CNT_W'(1));
    assign o_pop    = take && is_last;
    assign o_valid  = r_valid;
    assign o_data   = r_data;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data <= '{sel.kind, sel.start_pos, sel.stop_pos, is_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (out_free) begin
                r_valid <= i_avail;
            end
            if (take) begin
                r_idx <= is_last ? '0 : r_idx + slx_pkg::IDX_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_shell_command_lexer.sv =====
// tb_shell_command_lexer: self-checking testbench for the streaming shell command lexer.
// Depends on slx_pkg (payload structs, token kinds, character codes) and shell_command_lexer.
// Predicts every token per character and checks the result stream under random idling.
module tb_shell_command_lexer;
    timeunit 1ns;
    timeprecision 1ps;

    import slx_pkg::*;

    // Lexer modes of the predictor.
    typedef enum logic [2:0] {
        LX_IDLE = 3'd0,
        LX_WORD = 3'd1,
        LX_VAR  = 3'd2,
        LX_STR  = 3'd3,
        LX_ESC  = 3'd4,
        LX_DROP = 3'd5
    } t_lex_mode;

    localparam int PHASE_CNT     = 4;
    localparam int PHASE_ITEMS   = 55;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_TRIGGER  = 40;
    localparam int TAIL_CYCLES   = 20;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_in_item  i_data  = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_data;

    // Characters waiting to be offered, the line under construction, the
    // tokens one character causes, and the tokens still owed by the block.
    t_in_item   char_feed_q[$];
    logic [7:0] line_q[$];
    t_out_item  char_toks_q[$];
    t_out_item  tok_expect_q[$];

    // Predictor state.
    t_lex_mode   mode_q      = LX_IDLE;
    logic        dquote_q    = 1'b0;
    int unsigned tok_start_q = 0;
    int unsigned pos_q       = 0;

    int n_pushed     = 0;
    int n_accepted   = 0;
    int n_checked    = 0;
    int n_errors     = 0;
    int n_in_stalled = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    shell_command_lexer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // Character classes, written out independently of the design package.
    // ------------------------------------------------------------------
    function automatic bit name_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_USCORE || c == CH_DASH;
    endfunction

    function automatic bit blank_char(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    task automatic add_tok(input logic [2:0] kind, input int unsigned s, input int unsigned e);
        t_out_item t;
        t.kind      = kind;
        t.start_pos = POS_W'(s);
        t.stop_pos  = POS_W'(e);
        t.run_last  = 1'b0;
        char_toks_q.push_back(t);
    endtask

    // Lex a character that arrives with no token pending.
    task automatic open_tok(input logic [7:0] c, input int unsigned p);
        mode_q = LX_IDLE;
        if (c == CH_PIPE) begin
            add_tok(K_PIPE, p, p + 1);
        end else if (c == CH_LT) begin
            add_tok(K_IN, p, p + 1);
        end else if (c == CH_GT) begin
            add_tok(K_OUT, p, p + 1);
        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            // Open a string: the content starts after the quote.
            mode_q      = LX_STR;
            dquote_q    = (c == CH_DQUOTE);
            tok_start_q = p + 1;
        end else if (c == CH_DOLLAR) begin
            mode_q      = LX_VAR;
            tok_start_q = p + 1;
        end else if (name_char(c)) begin
            mode_q      = LX_WORD;
            tok_start_q = p;
        end else if (!blank_char(c)) begin
            // Unexpected character: flag it and drop the rest of the line.
            add_tok(K_ERR, p, p + 1);
            mode_q = LX_DROP;
        end
    endtask

    // Advance the predictor by one accepted character and queue its tokens.
    task automatic lex_char(input t_in_item it);
        int unsigned p;
        int unsigned len;
        logic [7:0]  c;
        t_out_item   t;
        c = it.ch;
        p = pos_q;
        char_toks_q.delete();
        if (mode_q != LX_DROP && p >= MAX_LEN) begin
            // Line too long: discard any pending token.
            add_tok(K_ERR, p, p + 1);
            mode_q = LX_DROP;
        end else begin
            case (mode_q)
                LX_IDLE: open_tok(c, p);
                LX_WORD, LX_VAR: begin
                    // A non-name character closes the token and is lexed anew.
                    if (!name_char(c)) begin
                        add_tok((mode_q == LX_WORD) ? K_STR : K_VAR, tok_start_q, p);
                        open_tok(c, p);
                    end
                end
                LX_STR: begin
                    if (c == (dquote_q ? CH_DQUOTE : CH_SQUOTE)) begin
                        add_tok(K_STR, tok_start_q, p);
                        mode_q = LX_IDLE;
                    end else if (c == CH_BSLASH) begin
                        mode_q = LX_ESC;
                    end
                end
                LX_ESC: mode_q = LX_STR;
                default: ;
            endcase
        end
        if (it.line_end) begin
            // Flush the pending token, then always close with an end marker.
            len = (p < MAX_LEN) ? p + 1 : MAX_LEN;
            if (mode_q inside {LX_WORD, LX_STR, LX_ESC}) begin
                add_tok(K_STR, tok_start_q, len);
            end else if (mode_q == LX_VAR) begin
                add_tok(K_VAR, tok_start_q, len);
            end
            add_tok(K_END, 0, len);
            mode_q = LX_IDLE;
            pos_q  = 0;
        end else begin
            pos_q = (p < MAX_LEN) ? p + 1 : MAX_LEN;
        end
        for (int i = 0; i < char_toks_q.size(); i++) begin
            t          = char_toks_q[i];
            t.run_last = (i == char_toks_q.size() - 1);
            tok_expect_q.push_back(t);
        end
    endtask

    // ------------------------------------------------------------------
    // Line builders
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_name();
        int r;
        r = $urandom_range(0, 63);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 52) return 8'h41 + 8'(r - 26);
        if (r < 62) return 8'h30 + 8'(r - 52);
        return (r == 62) ? CH_USCORE : CH_DASH;
    endfunction

    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? CH_SPACE : CH_TAB + 8'(r - 1);
    endfunction

    // Append one string character; never the closing quote unless escaped.
    task automatic add_str_char(input logic [7:0] quote);
        logic [7:0] c;
        if ($urandom_range(0, 4) == 0) begin
            line_q.push_back(CH_BSLASH);
            line_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            do begin
                c = 8'($urandom_range(0, 255));
            end while (c == quote || c == CH_BSLASH);
            line_q.push_back(c);
        end
    endtask

    // Hand the built line to the driver, marking its last character.
    task automatic flush_line();
        t_in_item t;
        for (int i = 0; i < line_q.size(); i++) begin
            t.ch       = line_q[i];
            t.line_end = (i == line_q.size() - 1);
            char_feed_q.push_back(t);
            n_pushed++;
        end
        line_q.delete();
    endtask

    // Mostly well-formed command lines with random content; some broken.
    task automatic rand_line();
        int         ntok;
        int         sel;
        logic [7:0] q;
        ntok = $urandom_range(1, 6);
        for (int k = 0; k < ntok; k++) begin
            // Usually separate tokens; sometimes let them touch.
            if (k > 0 && $urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 2)) line_q.push_back(rand_blank());
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2: repeat ($urandom_range(1, 6)) line_q.push_back(rand_name());
                3: begin
                    line_q.push_back(CH_DOLLAR);
                    repeat ($urandom_range(0, 4)) line_q.push_back(rand_name());
                end
                4, 5: begin
                    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                    line_q.push_back(q);
                    repeat ($urandom_range(0, 6)) add_str_char(q);
                    line_q.push_back(q);
                end
                6: line_q.push_back(CH_PIPE);
                7: line_q.push_back(CH_LT);
                8: line_q.push_back(CH_GT);
                default: line_q.push_back(rand_blank());
            endcase
        end
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            // Leave a string open to the end of the line.
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            line_q.push_back(q);
            repeat ($urandom_range(1, 5)) add_str_char(q);
        end else if (sel == 1) begin
            line_q.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
        end else if (sel == 2 || sel == 3) begin
            line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (sel == 4) begin
            line_q.push_back(8'($urandom_range(0, 255)));
        end
        flush_line();
    endtask

    // Hold until every character is taken and every token has come out.
    task automatic wait_drain();
        while (n_accepted != n_pushed || tok_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next character once the current transfer is done.
    // Never withdraw or change a stalled character.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                lex_char(i_data);
                n_accepted++;
            end
            if (i_valid && o_stall)
                n_in_stalled++;
            if (!i_valid || !o_stall) begin
                if (char_feed_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_data  <= char_feed_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall. Once, early on, hold off for a long stretch while the
    // sender keeps going, so the bundle queue fills and stalls the input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= HOLD_TRIGGER) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each token transfer with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_tok
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (tok_expect_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected token: kind %0d start %0d stop %0d last %0b",
                         $time, o_data.kind, o_data.start_pos, o_data.stop_pos,
                         o_data.run_last);
            end else begin
                want = tok_expect_q.pop_front();
                n_checked++;
                if (o_data.kind !== want.kind || o_data.start_pos !== want.start_pos ||
                    o_data.stop_pos !== want.stop_pos || o_data.run_last !== want.run_last) begin
                    n_errors++;
                    $display("%0t: token mismatch: expected kind %0d start %0d stop %0d last %0b",
                             $time, want.kind, want.start_pos, want.stop_pos, want.run_last);
                    $display("%0t:                 actual kind %0d start %0d stop %0d last %0b",
                             $time, o_data.kind, o_data.start_pos, o_data.stop_pos,
                             o_data.run_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int base;
        int idle_tbl[PHASE_CNT];
        int stall_tbl[PHASE_CNT];
        idle_tbl  = '{0, 77, 0, 22};
        stall_tbl = '{0, 0, 77, 22};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Word closed by a redirect, double-quoted string with an escaped
        // quote, empty variable closed by a pipe on the last character.
        line_q = '{8'h41, CH_USCORE, 8'h7A, CH_DASH, 8'h39, CH_LT, CH_DQUOTE,
                   CH_BSLASH, CH_DQUOTE, CH_DQUOTE, CH_DOLLAR, CH_PIPE};
        flush_line();
        // Single-quoted string holding a tab, then output redirect.
        line_q = '{CH_SQUOTE, 8'h78, CH_TAB, CH_SQUOTE, CH_GT};
        flush_line();
        // Word cut by NUL, then the rest dropped; end marker after the error.
        line_q = '{8'h61, 8'h00, 8'h62, 8'hFF};
        flush_line();
        // Variable closed by a blank, then an unterminated string.
        line_q = '{CH_DOLLAR, 8'h61, CH_CR, CH_DQUOTE, 8'h7A};
        flush_line();
        // Quote on the last character.
        line_q = '{CH_SPACE, CH_SQUOTE};
        flush_line();
        // Lone high byte.
        line_q = '{8'h80};
        flush_line();
        wait_drain();

        // Random lines under each idling mix.
        for (int ph = 0; ph < PHASE_CNT; ph++) begin
            send_idle_pct  = idle_tbl[ph];
            recv_stall_pct = stall_tbl[ph];
            base = n_pushed;
            while (n_pushed - base < PHASE_ITEMS) rand_line();
            wait_drain();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // Let any straggling transfer show up before judging.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("lexed %0d characters in %0d idling mixes, checked %0d tokens",
                 n_accepted, PHASE_CNT, n_checked);
        $display("input held by a full queue for %0d cycles", n_in_stalled);
        if (n_errors == 0 && tok_expect_q.size() == 0) begin
            $display("tb_shell_command_lexer: done, clean");
        end else begin
            $display("tb_shell_command_lexer: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("tb_shell_command_lexer: done, errors");
        $finish;
    end

endmodule
